### hdl/assert_macros.svh
// Assertion macros used by the checker file of the matrix multiply block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/mm_pkg.sv
// Shared types and constants of the matrix multiply block.
`timescale 1ns / 1ps

package mm_pkg;

    // Fixed field widths of the ports.
    localparam int KIND_W    = 2;
    localparam int IDX_W     = 3;
    localparam int IN_W      = 16;
    localparam int OUT_WIDTH = 35;
    localparam int CFG_W     = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Size register value after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Input beat kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    // Register indexes, taken from address bit 2.
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd;
        logic acc_clr;
        logic out_load;
        logic out_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_status;

endpackage

### hdl/matrix_multiply.sv
// Top level of the integer matrix multiply block.
//
//   Channel   Direction  Handshake                  Beat contents
//   input     in         i_in_valid / o_in_ready    kind, row, column, element value
//   output    out        o_out_valid / i_out_ready  row, column, product, last flag
//   config    in         psel / penable / pready    num_rows at 0x0, num_cols at 0x4
//
// Load beats are accepted back to back.
// A compute beat walks each result element; per element it issues depth store reads,
// depth being min(rows, cols), drains the multiply and accumulate stages and loads the
// output register, with output stalls adding to the run; a zero size gives no beats.
// Reset is synchronous and active low; the operand stores are not cleared.
// A stalled output holds the walk in its drain step until the beat is taken.
`timescale 1ns / 1ps

module matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mm_pkg::PADDR_W-1:0]           paddr,
    input  logic [mm_pkg::PDATA_W-1:0]           pwdata,
    output logic [mm_pkg::PDATA_W-1:0]           prdata,
    output logic                                 pready,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mm_pkg::KIND_W-1:0]            i_kind,
    input  logic [mm_pkg::IDX_W-1:0]             i_row_index,
    input  logic [mm_pkg::IDX_W-1:0]             i_col_index,
    input  logic signed [mm_pkg::IN_W-1:0]       i_element_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mm_pkg::IDX_W-1:0]             o_out_row,
    output logic [mm_pkg::IDX_W-1:0]             o_out_col,
    output logic signed [mm_pkg::OUT_WIDTH-1:0]  o_product_value,
    output logic                                 o_is_last
);

    localparam int DIM_W = $clog2(MAX_DIM);

    logic [mm_pkg::CFG_W-1:0] num_rows;
    logic [mm_pkg::CFG_W-1:0] num_cols;
    mm_pkg::t_cmd             cmd;
    mm_pkg::t_status          status;
    logic [DIM_W-1:0]         idx_i;
    logic [DIM_W-1:0]         idx_j;
    logic [DIM_W-1:0]         idx_k;

    // Size registers.
    mm_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_num_rows (num_rows),
        .o_num_cols (num_cols)
    );

    // Sequencer.
    mm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_num_rows  (num_rows),
        .i_num_cols  (num_cols),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_i         (idx_i),
        .o_j         (idx_j),
        .o_k         (idx_k)
    );

    // Stores and arithmetic.
    mm_dpath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .i_i             (idx_i),
        .i_j             (idx_j),
        .i_k             (idx_k),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_is_last       (o_is_last)
    );

endmodule

### hdl/mm_regs.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module mm_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mm_pkg::PADDR_W-1:0]    paddr,
    input  logic [mm_pkg::PDATA_W-1:0]    pwdata,
    output logic [mm_pkg::PDATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [mm_pkg::CFG_W-1:0]      o_num_rows,
    output logic [mm_pkg::CFG_W-1:0]      o_num_cols
);

    logic [mm_pkg::CFG_W-1:0] r_num_rows;
    logic [mm_pkg::CFG_W-1:0] r_num_cols;
    logic                     wr_en;
    logic                     reg_sel;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= mm_pkg::CFG_RESET;
            r_num_cols <= mm_pkg::CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                mm_pkg::REG_NUM_ROWS: r_num_rows <= pwdata[mm_pkg::CFG_W-1:0];
                mm_pkg::REG_NUM_COLS: r_num_cols <= pwdata[mm_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (reg_sel)
            mm_pkg::REG_NUM_ROWS: prdata = mm_pkg::PDATA_W'(r_num_rows);
            mm_pkg::REG_NUM_COLS: prdata = mm_pkg::PDATA_W'(r_num_cols);
            default:              prdata = '0;
        endcase
    end

    assign o_num_rows = r_num_rows;
    assign o_num_cols = r_num_cols;

endmodule

### hdl/mm_ctrl.sv
// Controller: accepts input beats and sequences the multiply-accumulate walk.
`timescale 1ns / 1ps

module mm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mm_pkg::KIND_W-1:0]     i_kind,
    input  logic [mm_pkg::IDX_W-1:0]      i_row_index,
    input  logic [mm_pkg::IDX_W-1:0]      i_col_index,
    input  logic [mm_pkg::CFG_W-1:0]      i_num_rows,
    input  logic [mm_pkg::CFG_W-1:0]      i_num_cols,
    input  mm_pkg::t_status               i_status,
    output mm_pkg::t_cmd                  o_cmd,
    output logic [$clog2(MAX_DIM)-1:0]    o_i,
    output logic [$clog2(MAX_DIM)-1:0]    o_j,
    output logic [$clog2(MAX_DIM)-1:0]    o_k
);

    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_rows, n_rows;
    logic [CNT_W-1:0] r_cols, n_cols;
    logic [CNT_W-1:0] r_depth, n_depth;
    logic [DIM_W-1:0] r_i, n_i;
    logic [DIM_W-1:0] r_j, n_j;
    logic [DIM_W-1:0] r_k, n_k;

    logic             in_fire;
    logic             wr_ok;
    logic [CNT_W-1:0] eff_rows;
    logic [CNT_W-1:0] eff_cols;
    logic [CNT_W-1:0] eff_depth;
    logic             last_row;
    logic             last_col;
    logic             last_k;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid & o_in_ready;

    // Writes outside the store are dropped.
    assign wr_ok = (32'(i_row_index) < MAX_DIM) && (32'(i_col_index) < MAX_DIM);

    // Size registers saturate at the store dimension.
    assign eff_rows  = (32'(i_num_rows) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(i_num_rows);
    assign eff_cols  = (32'(i_num_cols) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(i_num_cols);
    assign eff_depth = (eff_rows < eff_cols) ? eff_rows : eff_cols;

    assign last_row = (CNT_W'(r_i) + CNT_W'(1)) == r_rows;
    assign last_col = (CNT_W'(r_j) + CNT_W'(1)) == r_cols;
    assign last_k   = (CNT_W'(r_k) + CNT_W'(1)) == r_depth;

    // Next-state and command logic.
    always_comb begin
        n_state = r_state;
        n_rows  = r_rows;
        n_cols  = r_cols;
        n_depth = r_depth;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_kind)
                        mm_pkg::KIND_LOAD_A: o_cmd.wr_a = wr_ok;
                        mm_pkg::KIND_LOAD_B: o_cmd.wr_b = wr_ok;
                        mm_pkg::KIND_COMPUTE: begin
                            // An empty result matrix gives no beats at all.
                            if (eff_rows != '0 && eff_cols != '0) begin
                                n_rows        = eff_rows;
                                n_cols        = eff_cols;
                                n_depth       = eff_depth;
                                n_i           = '0;
                                n_j           = '0;
                                n_k           = '0;
                                o_cmd.acc_clr = 1'b1;
                                n_state       = ST_ISSUE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE: begin
                // One store read pair per cycle along the inner dimension.
                o_cmd.rd = 1'b1;
                if (last_k) begin
                    n_k     = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_k = DIM_W'(r_k + DIM_W'(1));
                end
            end
            ST_DRAIN: begin
                // Emit once the pipeline is empty and the output stage is free.
                if (!i_status.busy && i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.acc_clr  = 1'b1;
                    o_cmd.out_last = last_row & last_col;
                    if (last_col) begin
                        n_j = '0;
                        if (last_row) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_i     = DIM_W'(r_i + DIM_W'(1));
                            n_state = ST_ISSUE;
                        end
                    end else begin
                        n_j     = DIM_W'(r_j + DIM_W'(1));
                        n_state = ST_ISSUE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rows  <= '0;
            r_cols  <= '0;
            r_depth <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_rows  <= n_rows;
            r_cols  <= n_cols;
            r_depth <= n_depth;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign o_i = r_i;
    assign o_j = r_j;
    assign o_k = r_k;

endmodule

### hdl/mm_dpath.sv
// Datapath: operand stores, multiply-accumulate pipeline and output register.
`timescale 1ns / 1ps

module mm_dpath #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mm_pkg::t_cmd                         i_cmd,
    output mm_pkg::t_status                      o_status,
    input  logic [mm_pkg::IDX_W-1:0]             i_row_index,
    input  logic [mm_pkg::IDX_W-1:0]             i_col_index,
    input  logic signed [mm_pkg::IN_W-1:0]       i_element_value,
    input  logic [$clog2(MAX_DIM)-1:0]           i_i,
    input  logic [$clog2(MAX_DIM)-1:0]           i_j,
    input  logic [$clog2(MAX_DIM)-1:0]           i_k,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mm_pkg::IDX_W-1:0]             o_out_row,
    output logic [mm_pkg::IDX_W-1:0]             o_out_col,
    output logic signed [mm_pkg::OUT_WIDTH-1:0]  o_product_value,
    output logic                                 o_is_last
);

    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int PROD_W    = 2 * ELEM_WIDTH;

    logic signed [ELEM_WIDTH-1:0]       r_mem_a [MEM_DEPTH];
    logic signed [ELEM_WIDTH-1:0]       r_mem_b [MEM_DEPTH];
    logic signed [ELEM_WIDTH-1:0]       r_a_rd;
    logic signed [ELEM_WIDTH-1:0]       r_b_rd;
    logic                               r_rd_v;
    logic signed [PROD_W-1:0]           r_prod;
    logic                               r_prod_v;
    logic signed [mm_pkg::OUT_WIDTH-1:0] r_acc;
    logic                               r_out_valid;
    logic [mm_pkg::IDX_W-1:0]           r_out_row;
    logic [mm_pkg::IDX_W-1:0]           r_out_col;
    logic signed [mm_pkg::OUT_WIDTH-1:0] r_out_value;
    logic                               r_out_last;

    logic [ADDR_W-1:0]                  wr_addr;
    logic [ADDR_W-1:0]                  a_addr;
    logic [ADDR_W-1:0]                  b_addr;
    logic signed [ELEM_WIDTH-1:0]       wr_data;

    // Row-major store addresses.
    assign wr_addr = ADDR_W'(ADDR_W'(i_row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(i_col_index));
    assign a_addr  = ADDR_W'(ADDR_W'(i_i) * ADDR_W'(MAX_DIM) + ADDR_W'(i_k));
    assign b_addr  = ADDR_W'(ADDR_W'(i_k) * ADDR_W'(MAX_DIM) + ADDR_W'(i_j));

    // The element keeps its low bits, sign-extended to the store width.
    assign wr_data = ELEM_WIDTH'(i_element_value);

    // Operand stores: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_a_rd <= r_mem_a[a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            r_mem_b[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_b_rd <= r_mem_b[b_addr];
        end
    end

    // Multiply stage and pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.rd;
            r_prod_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_a_rd * r_b_rd;
    end

    // Accumulator wraps at the output width.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + mm_pkg::OUT_WIDTH'(r_prod);
        end
    end

    // Output register holds one beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row   <= mm_pkg::IDX_W'(i_i);
            r_out_col   <= mm_pkg::IDX_W'(i_j);
            r_out_value <= r_acc;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_status.busy     = r_rd_v | r_prod_v;
    assign o_status.out_free = ~r_out_valid | i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = r_out_value;
    assign o_is_last       = r_out_last;

endmodule

### hdl/mm_checker.sv
// Port-level checks of the matrix multiply block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mm_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_ready,
    input  logic [mm_pkg::KIND_W-1:0]            i_kind,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [mm_pkg::OUT_WIDTH-1:0]  o_product_value
);

    logic load_beat;

    // An accepted beat that is not a compute command.
    assign load_beat = i_in_valid && o_in_ready && (i_kind != mm_pkg::KIND_COMPUTE);

    // A beat that is not a compute command never makes the block busy.
    `CHK_NEXT(a_load_keeps_ready, i_clk, i_rst_n, load_beat, o_in_ready)

    // New result beats only appear while a compute run holds off the input side.
    `CHK_IMPLIES(a_result_while_busy, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready))

    // A stalled result beat stays and holds its sum.
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_product_value))

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);
